// File: design/dtq_pkg.sv
// Shared types and constants for the deadline timer queue.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dtq_pkg;
  localparam int SLOTS    = 16;
  localparam int SLOT_W   = 4;
  localparam int FIRE_CAP = 16;
  localparam int CNT_W    = 5;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_CANCEL = 3'd1;
  localparam logic [2:0] OP_ABS    = 3'd2;
  localparam logic [2:0] OP_GAME   = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;
  localparam logic [2:0] OP_NOP    = 3'd7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_NOSUCH  = 2'd3;

  localparam logic [2:0] HINT_MAX = 3'd5;

  typedef struct packed {
    logic [2:0]  operation;
    logic        clock_kind;
    logic [31:0] delay;
    logic        repeat_req;
    logic [3:0]  handle;
    logic [31:0] time_value;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       fired;
    logic [3:0] slot;
    logic       is_last;
    logic [2:0] wait_hint;
  } out_t;

  typedef struct packed {
    logic [2:0]  op;
    logic        clock_kind;
    logic [31:0] delay;
    logic        repeat_req;
    logic [3:0]  handle;
    logic [31:0] time_value;
  } cmd_t;
endpackage
`default_nettype wire

// File: design/dtq_front.sv
// Front end: accepts input words, decodes the operation, queues commands.
// Depends on dtq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dtq_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire dtq_pkg::in_t  in_data,
  output logic               cmd_valid,
  input  wire logic          cmd_pop,
  output dtq_pkg::cmd_t      cmd
);
  dtq_pkg::cmd_t q [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  dtq_pkg::cmd_t dec;
  logic          push;
  logic          pop;

  always_comb begin
    dec.clock_kind = in_data.clock_kind;
    dec.delay      = in_data.delay;
    dec.repeat_req = in_data.repeat_req;
    dec.handle     = in_data.handle;
    dec.time_value = in_data.time_value;
    unique case (in_data.operation) inside
      dtq_pkg::OP_ADD, dtq_pkg::OP_CANCEL, dtq_pkg::OP_ABS,
      dtq_pkg::OP_GAME, dtq_pkg::OP_CLEAR: dec.op = in_data.operation;
      default: dec.op = dtq_pkg::OP_NOP;
    endcase
  end

  assign in_ready  = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= dec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

// File: design/dtq_back.sv
// Back end: timer table, sequential scans for due entries and wait hint,
// result buffer and output register. Depends on dtq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dtq_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_pop,
  input  wire dtq_pkg::cmd_t cmd,
  output logic               out_valid,
  input  wire logic          out_ready,
  output dtq_pkg::out_t      out_data
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FIRE  = 3'd3;
  localparam logic [2:0] S_HSCAN = 3'd4;
  localparam logic [2:0] S_HINT  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;
  localparam logic [dtq_pkg::SLOT_W-1:0] LAST = dtq_pkg::SLOT_W'(dtq_pkg::SLOTS - 1);

  logic [2:0]  state;
  dtq_pkg::cmd_t c;
  logic [dtq_pkg::SLOTS-1:0] valid;
  logic [dtq_pkg::SLOTS-1:0] eclk;
  logic [63:0] dl  [dtq_pkg::SLOTS];
  logic [31:0] per [dtq_pkg::SLOTS];
  logic [31:0] ord [dtq_pkg::SLOTS];
  logic [31:0] counter;
  logic [63:0] abs_clock;
  logic [63:0] now;
  logic        tick_ck;
  logic [dtq_pkg::SLOT_W-1:0] idx;
  logic        found;
  logic [dtq_pkg::SLOT_W-1:0] best_idx;
  logic [63:0] best_dl;
  logic [31:0] best_age;
  logic [dtq_pkg::CNT_W-1:0] fires;
  logic [dtq_pkg::CNT_W-1:0] nres;
  logic [dtq_pkg::CNT_W-1:0] emit_idx;
  logic [1:0]  res_status [dtq_pkg::FIRE_CAP];
  logic        res_fired  [dtq_pkg::FIRE_CAP];
  logic [3:0]  res_slot   [dtq_pkg::FIRE_CAP];
  logic [63:0] earliest;
  logic        any;
  logic [2:0]  hint;

  logic [dtq_pkg::SLOT_W-1:0] rd_idx;
  logic [63:0] rd_dl;
  logic [31:0] rd_age;
  logic        due;
  logic        better;
  logic [dtq_pkg::SLOT_W-1:0] free_idx;
  logic        any_free;
  logic [63:0] diff;
  logic        res_we;
  logic [1:0]  res_st_w;
  logic        res_fi_w;
  logic [3:0]  res_sl_w;

  assign rd_idx = (state == S_FIRE) ? best_idx : idx;
  assign rd_dl  = dl[rd_idx];
  assign rd_age = counter - ord[rd_idx];
  assign due    = valid[rd_idx] && (eclk[rd_idx] == tick_ck) && (rd_dl <= now);
  assign better = !found || (rd_dl < best_dl) || ((rd_dl == best_dl) && (rd_age > best_age));
  assign diff   = earliest - abs_clock;
  assign any_free = ~&valid;
  assign cmd_pop  = (state == S_IDLE);

  always_comb begin
    free_idx = '0;
    for (int i = dtq_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!valid[i]) free_idx = dtq_pkg::SLOT_W'(i);
    end
  end

  // result buffer write
  always_comb begin
    res_we   = 1'b0;
    res_st_w = dtq_pkg::ST_OK;
    res_fi_w = 1'b0;
    res_sl_w = '0;
    if (state == S_EXEC) begin
      res_we = (c.op != dtq_pkg::OP_ABS) && (c.op != dtq_pkg::OP_GAME);
      if (c.op == dtq_pkg::OP_ADD) begin
        if (c.delay == 32'd0) res_st_w = dtq_pkg::ST_INVALID;
        else if (!any_free) res_st_w = dtq_pkg::ST_FULL;
        else res_sl_w = free_idx;
      end else if (c.op == dtq_pkg::OP_CANCEL) begin
        res_sl_w = c.handle;
        if (!valid[c.handle]) res_st_w = dtq_pkg::ST_NOSUCH;
      end
    end else if (state == S_FIRE) begin
      res_we   = 1'b1;
      res_fi_w = 1'b1;
      res_sl_w = best_idx;
    end else if (state == S_SCAN && idx == LAST && !(found || due) && nres == '0) begin
      res_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_we) begin
      res_status[nres[dtq_pkg::SLOT_W-1:0]] <= res_st_w;
      res_fired[nres[dtq_pkg::SLOT_W-1:0]]  <= res_fi_w;
      res_slot[nres[dtq_pkg::SLOT_W-1:0]]   <= res_sl_w;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (state == S_EXEC && c.op == dtq_pkg::OP_ADD && c.delay != 32'd0 && any_free) begin
      dl[free_idx]   <= {32'd0, c.delay} + (c.clock_kind ? abs_clock : {32'd0, c.time_value});
      per[free_idx]  <= c.repeat_req ? c.delay : 32'd0;
      ord[free_idx]  <= counter;
      eclk[free_idx] <= c.clock_kind;
    end else if (state == S_FIRE && per[best_idx] != 32'd0) begin
      dl[best_idx]  <= rd_dl + {32'd0, per[best_idx]};
      ord[best_idx] <= counter;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) c <= cmd;
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
      counter   <= '0;
      abs_clock <= '0;
      out_valid <= 1'b0;
      nres      <= '0;
      emit_idx  <= '0;
      fires     <= '0;
      found     <= 1'b0;
      any       <= 1'b0;
      idx       <= '0;
    end else begin
      if (res_we) nres <= nres + 1'b1;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          nres <= '0;
          if (cmd_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          idx   <= '0;
          any   <= 1'b0;
          found <= 1'b0;
          fires <= '0;
          state <= S_HSCAN;
          case (c.op)
            dtq_pkg::OP_ADD: begin
              if (c.delay != 32'd0 && any_free) begin
                valid[free_idx] <= 1'b1;
                counter <= counter + 32'd1;
              end
            end
            dtq_pkg::OP_CANCEL: valid[c.handle] <= 1'b0;
            dtq_pkg::OP_CLEAR:  valid <= valid & eclk;
            dtq_pkg::OP_ABS: begin
              abs_clock <= abs_clock + {32'd0, c.time_value};
              now       <= abs_clock + {32'd0, c.time_value};
              tick_ck   <= 1'b1;
              state     <= S_SCAN;
            end
            dtq_pkg::OP_GAME: begin
              now     <= {32'd0, c.time_value};
              tick_ck <= 1'b0;
              state   <= S_SCAN;
            end
            default: ;
          endcase
        end
        S_SCAN: begin
          if (due && better) begin
            found    <= 1'b1;
            best_idx <= idx;
            best_dl  <= rd_dl;
            best_age <= rd_age;
          end
          idx <= idx + 1'b1;
          if (idx == LAST) begin
            idx   <= '0;
            state <= (found || due) ? S_FIRE : S_HSCAN;
          end
        end
        S_FIRE: begin
          if (per[best_idx] != 32'd0) counter <= counter + 32'd1;
          else valid[best_idx] <= 1'b0;
          fires <= fires + 1'b1;
          found <= 1'b0;
          idx   <= '0;
          state <= (fires + 1'b1 == dtq_pkg::CNT_W'(dtq_pkg::FIRE_CAP)) ? S_HSCAN : S_SCAN;
        end
        S_HSCAN: begin
          if (valid[idx] && eclk[idx] && (!any || rd_dl < earliest)) begin
            earliest <= rd_dl;
            any      <= 1'b1;
          end
          idx <= idx + 1'b1;
          if (idx == LAST) state <= S_HINT;
        end
        S_HINT: begin
          if (!any) hint <= dtq_pkg::HINT_MAX;
          else if (earliest < abs_clock) hint <= 3'd0;
          else if (diff < 64'(dtq_pkg::HINT_MAX)) hint <= diff[2:0];
          else hint <= dtq_pkg::HINT_MAX;
          emit_idx <= '0;
          state    <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid          <= 1'b1;
            out_data.status    <= res_status[emit_idx[dtq_pkg::SLOT_W-1:0]];
            out_data.fired     <= res_fired[emit_idx[dtq_pkg::SLOT_W-1:0]];
            out_data.slot      <= res_slot[emit_idx[dtq_pkg::SLOT_W-1:0]];
            out_data.wait_hint <= hint;
            out_data.is_last   <= (emit_idx + 1'b1 == nres);
            emit_idx           <= emit_idx + 1'b1;
            if (emit_idx + 1'b1 == nres) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: design/deadline_timer_queue.sv
// Top level of the deadline timer queue: front decode queue and back engine.
// Depends on dtq_pkg, dtq_front, dtq_back.
// One word is worked at a time. Each scan walks the whole 16-entry table.
// An add, cancel, clear or unknown operation gives one result; a tick that
// fires n timers gives n results (at most 16, the fire cap), or one result
// if none fire. After the first result, one further result goes out per
// cycle while the result side is ready; a stall there holds the next result.
// A two-entry command queue takes new words while the engine is busy.
`timescale 1ns / 1ps
`default_nettype none
module deadline_timer_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire dtq_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output dtq_pkg::out_t      out_data
);
  logic          cmd_valid;
  logic          cmd_pop;
  dtq_pkg::cmd_t cmd;

  dtq_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd(cmd)
  );

  dtq_back u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd(cmd),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

`ifndef SYNTHESIS
  a_hint_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.wait_hint <= dtq_pkg::HINT_MAX)
    else $error("wait hint out of range");
  a_fired_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.fired |-> out_data.status == dtq_pkg::ST_OK)
    else $error("fired result with error status");
  a_err_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == dtq_pkg::ST_FULL ||
      out_data.status == dtq_pkg::ST_INVALID) |-> out_data.slot == 4'd0)
    else $error("rejected add reports a slot");
`endif
endmodule
`default_nettype wire

// File: test/dtq_checker.sv
// Checker for the deadline timer queue: watches both channels, predicts each
// result word from a local copy of the timer table and compares. Uses dtq_pkg.
`timescale 1ns / 1ps
module dtq_checker (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          in_ready,
  input  wire dtq_pkg::in_t  in_data,
  input  wire logic          out_valid,
  input  wire logic          out_ready,
  input  wire dtq_pkg::out_t out_data,
  output int                 errors,
  output int                 pending,
  output int                 fires_seen
);
  logic          tv_valid [dtq_pkg::SLOTS];
  logic [63:0]   tv_deadline [dtq_pkg::SLOTS];
  logic [31:0]   tv_period [dtq_pkg::SLOTS];
  logic          tv_clock [dtq_pkg::SLOTS];
  logic [31:0]   tv_order [dtq_pkg::SLOTS];
  logic [31:0]   seq_count;
  logic [63:0]   abs_now;
  dtq_pkg::out_t expected_words[$];

  function automatic int find_due(logic ck, logic [63:0] now);
    int best;
    best = -1;
    for (int i = 0; i < dtq_pkg::SLOTS; i++) begin
      if (!tv_valid[i] || tv_clock[i] != ck || tv_deadline[i] > now) continue;
      if (best < 0 || tv_deadline[i] < tv_deadline[best] ||
          (tv_deadline[i] == tv_deadline[best] &&
           (seq_count - tv_order[i]) > (seq_count - tv_order[best])))
        best = i;
    end
    return best;
  endfunction

  function automatic logic [2:0] hint_now();
    logic        any;
    logic [63:0] earliest;
    any = 0;
    earliest = 0;
    for (int i = 0; i < dtq_pkg::SLOTS; i++)
      if (tv_valid[i] && tv_clock[i] && (!any || tv_deadline[i] < earliest)) begin
        earliest = tv_deadline[i];
        any = 1;
      end
    if (!any) return dtq_pkg::HINT_MAX;
    if (earliest < abs_now) return 3'd0;
    earliest = earliest - abs_now;
    return earliest < 64'(dtq_pkg::HINT_MAX) ? earliest[2:0] : dtq_pkg::HINT_MAX;
  endfunction

  task automatic push_word(logic [1:0] st, logic f, logic [3:0] s);
    dtq_pkg::out_t w;
    w = '0;
    w.status = st;
    w.fired = f;
    w.slot = s;
    expected_words.push_back(w);
  endtask

  task automatic run_tick(logic ck, logic [63:0] now);
    int n;
    int s;
    n = 0;
    while (n < dtq_pkg::FIRE_CAP) begin
      s = find_due(ck, now);
      if (s < 0) break;
      push_word(dtq_pkg::ST_OK, 1'b1, 4'(s));
      n++;
      if (tv_period[s] != 0) begin
        tv_deadline[s] = tv_deadline[s] + 64'(tv_period[s]);
        tv_order[s] = seq_count;
        seq_count = seq_count + 1;
      end else begin
        tv_valid[s] = 0;
      end
    end
    if (n == 0) push_word(dtq_pkg::ST_OK, 1'b0, 4'd0);
  endtask

  task automatic predict(dtq_pkg::in_t w);
    int first;
    int s;
    logic [2:0] h;
    first = expected_words.size();
    s = -1;
    case (w.operation)
      dtq_pkg::OP_ADD: begin
        if (w.delay == 0) begin
          push_word(dtq_pkg::ST_INVALID, 1'b0, 4'd0);
        end else begin
          for (int i = dtq_pkg::SLOTS - 1; i >= 0; i--) if (!tv_valid[i]) s = i;
          if (s < 0) begin
            push_word(dtq_pkg::ST_FULL, 1'b0, 4'd0);
          end else begin
            tv_valid[s] = 1;
            tv_clock[s] = w.clock_kind;
            tv_deadline[s] = 64'(w.delay) + (w.clock_kind ? abs_now : 64'(w.time_value));
            tv_period[s] = w.repeat_req ? w.delay : 32'd0;
            tv_order[s] = seq_count;
            seq_count = seq_count + 1;
            push_word(dtq_pkg::ST_OK, 1'b0, 4'(s));
          end
        end
      end
      dtq_pkg::OP_CANCEL: begin
        if (tv_valid[w.handle]) begin
          tv_valid[w.handle] = 0;
          push_word(dtq_pkg::ST_OK, 1'b0, w.handle);
        end else begin
          push_word(dtq_pkg::ST_NOSUCH, 1'b0, w.handle);
        end
      end
      dtq_pkg::OP_ABS: begin
        abs_now = abs_now + 64'(w.time_value);
        run_tick(1'b1, abs_now);
      end
      dtq_pkg::OP_GAME: run_tick(1'b0, 64'(w.time_value));
      dtq_pkg::OP_CLEAR: begin
        for (int i = 0; i < dtq_pkg::SLOTS; i++)
          if (tv_valid[i] && !tv_clock[i]) tv_valid[i] = 0;
        push_word(dtq_pkg::ST_OK, 1'b0, 4'd0);
      end
      default: push_word(dtq_pkg::ST_OK, 1'b0, 4'd0);
    endcase
    h = hint_now();
    for (int i = first; i < expected_words.size(); i++) expected_words[i].wait_hint = h;
    expected_words[expected_words.size() - 1].is_last = 1'b1;
  endtask

  always @(posedge clk) begin
    dtq_pkg::out_t e;
    if (rst) begin
      for (int i = 0; i < dtq_pkg::SLOTS; i++) begin
        tv_valid[i] = 0;
        tv_deadline[i] = '0;
        tv_period[i] = '0;
        tv_clock[i] = 0;
        tv_order[i] = '0;
      end
      seq_count = '0;
      abs_now = '0;
      errors <= 0;
      fires_seen <= 0;
      expected_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (out_data.fired === 1'b1) fires_seen <= fires_seen + 1;
        if (expected_words.size() == 0) begin
          if (errors < 10) $display("unexpected result word %p", out_data);
          errors <= errors + 1;
        end else begin
          e = expected_words[0];
          expected_words.delete(0);
          if (out_data !== e) begin
            if (errors < 10) $display("mismatch: expected %p, got %p", e, out_data);
            errors <= errors + 1;
          end
        end
      end
      if (in_valid && in_ready) predict(in_data);
    end
    pending = expected_words.size();
  end
endmodule

// File: test/tb_top.sv
// Stimulus and verdict for the deadline timer queue test.
// Depends on dtq_pkg, deadline_timer_queue and dtq_checker.
`timescale 1ns / 1ps
module tb_top;
  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_ready;
  dtq_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  dtq_pkg::out_t out_data;
  int   errors;
  int   pending;
  int   fires_seen;
  int   cycle_count;
  int   items_sent;
  bit   calm;
  logic [31:0] game_now;

  localparam int CYCLE_LIMIT = 2000000;

  deadline_timer_queue dut (.*);
  dtq_checker chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int gap;
    out_ready = 0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 15);
        out_ready = 0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1;
    end
  end

  task automatic send(dtq_pkg::in_t w);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid = 0;
      gap = $urandom_range(1, 15);
      repeat (gap) @(negedge clk);
    end
    in_data = w;
    in_valid = 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
    in_valid = 0;
  endtask

  function automatic dtq_pkg::in_t mk(logic [2:0] op, logic ck, logic [31:0] dl, logic rp,
                                      logic [3:0] hd, logic [31:0] tv);
    dtq_pkg::in_t w;
    w.operation = op;
    w.clock_kind = ck;
    w.delay = dl;
    w.repeat_req = rp;
    w.handle = hd;
    w.time_value = tv;
    return w;
  endfunction

  function automatic logic [31:0] rnd32();
    return $urandom();
  endfunction

  function automatic dtq_pkg::in_t rand_word();
    dtq_pkg::in_t w;
    int pick;
    w = mk(dtq_pkg::OP_NOP, 1'($urandom_range(0, 1)), rnd32(), 1'($urandom_range(0, 1)),
           4'($urandom_range(0, 15)), rnd32());
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      w.operation = dtq_pkg::OP_ADD;
      w.delay = ($urandom_range(0, 9) == 0) ? rnd32() : $urandom_range(0, 12);
      w.time_value = game_now;
    end else if (pick < 52) begin
      w.operation = dtq_pkg::OP_CANCEL;
    end else if (pick < 74) begin
      w.operation = dtq_pkg::OP_ABS;
      w.time_value = ($urandom_range(0, 19) == 0) ? rnd32() : $urandom_range(0, 6);
    end else if (pick < 92) begin
      w.operation = dtq_pkg::OP_GAME;
      game_now = game_now + $urandom_range(0, 6);
      w.time_value = ($urandom_range(0, 29) == 0) ? rnd32() : game_now;
    end else if (pick < 96) begin
      w.operation = dtq_pkg::OP_CLEAR;
    end else begin
      w.operation = 3'($urandom_range(5, 7));
    end
    return w;
  endfunction

  initial begin
    rst = 1;
    in_valid = 0;
    in_data = '0;
    cycle_count = 0;
    items_sent = 0;
    calm = 0;
    game_now = 0;
    repeat (5) @(negedge clk);
    rst = 0;

    send(mk(dtq_pkg::OP_ADD, 1'b1, 32'd0, 1'b0, 4'd0, 32'd0));
    send(mk(dtq_pkg::OP_CANCEL, 1'b0, 32'd0, 1'b0, 4'd15, 32'hFFFF_FFFF));
    send(mk(dtq_pkg::OP_ADD, 1'b1, 32'd3, 1'b1, 4'd0, 32'd0));
    send(mk(dtq_pkg::OP_ADD, 1'b1, 32'd3, 1'b0, 4'd0, 32'd0));
    send(mk(dtq_pkg::OP_ADD, 1'b0, 32'hFFFF_FFFF, 1'b1, 4'hF, 32'hFFFF_FFFF));
    send(mk(dtq_pkg::OP_ADD, 1'b0, 32'd2, 1'b0, 4'd0, 32'd10));
    send(mk(dtq_pkg::OP_ABS, 1'b0, 32'd0, 1'b0, 4'd0, 32'd3));
    send(mk(dtq_pkg::OP_ABS, 1'b0, 32'd0, 1'b0, 4'd0, 32'd10));
    send(mk(dtq_pkg::OP_GAME, 1'b0, 32'd0, 1'b0, 4'd0, 32'd12));
    send(mk(dtq_pkg::OP_CANCEL, 1'b0, 32'd0, 1'b0, 4'd0, 32'd0));
    for (int i = 0; i < 17; i++)
      send(mk(dtq_pkg::OP_ADD, i[0], 32'd1, 1'b1, 4'd0, 32'd20));
    send(mk(dtq_pkg::OP_GAME, 1'b0, 32'd0, 1'b0, 4'd0, 32'hFFFF_FFFF));
    send(mk(dtq_pkg::OP_ABS, 1'b0, 32'd0, 1'b0, 4'd0, 32'hFFFF_FFFF));
    send(mk(dtq_pkg::OP_CLEAR, 1'b0, 32'd0, 1'b0, 4'd0, 32'd0));
    send(mk(3'd5, 1'b0, 32'd0, 1'b0, 4'd0, 32'd0));
    send(mk(3'd6, 1'b1, 32'hFFFF_FFFF, 1'b1, 4'hF, 32'hFFFF_FFFF));
    send(mk(dtq_pkg::OP_NOP, 1'b0, 32'd0, 1'b0, 4'd0, 32'd0));
    for (int i = 0; i < 16; i++)
      send(mk(dtq_pkg::OP_CANCEL, 1'b0, 32'd0, 1'b0, 4'(i), 32'd0));

    for (int n = 0; n < 432; n++) begin
      if (n == 380) calm = 1;
      send(rand_word());
    end

    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("sent %0d words, %0d timer firings checked", items_sent, fires_seen);
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
